@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and the screen address mapping of the text-mode
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    // Derived widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int TAB_W  = $clog2(TAB_WIDTH) + 1;

    // Port field widths
    localparam int REQ_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int COLOR_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Control bytes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET   = 4'h7;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;
    localparam logic [ATTR_W-1:0]  RESET_ATTR = 8'h07;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_PUT   = 6'b000100,
        ST_BLANK = 6'b001000,
        ST_READ  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Map a screen position to a memory address; the top row rotates.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] lin,
                                                    input logic [ADDR_W-1:0] base);
        logic [ADDR_W:0] sum;
        sum = {1'b0, lin} + {1'b0, base};
        if (sum >= (ADDR_W + 1)'(CELLS)) begin
            sum = sum - (ADDR_W + 1)'(CELLS);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/text_mode_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_mode_console_writer_top
// 80x25 text console: character/attribute screen memory with a write cursor.
// ----------------------------------------------------------------------------
// The screen lives in one 2000 x 16 memory (character low byte, attribute
// high byte) with a single write port, and every cell write goes through
// that port. One item is handled at a time. A tab writes blanks up to the
// next tab stop (at most TAB_WIDTH). A byte or tab space that meets a full
// line wraps first and is stored after the wrap. Scrolling rotates the
// top-row offset instead of moving data, so a scroll only has to blank the
// new bottom row. A clear blanks every cell. After reset, s_ready stays low
// while the memory is filled with blank cells; configuration writes are
// taken during that pass. The result register lets the next item transfer
// in while a result is still waiting on m_ready.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration
    input  logic                          cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata,
    // Request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcw_pkg::REQ_W-1:0]     s_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     s_cell_index,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcw_pkg::POS_W-1:0]     m_cursor_pos,
    output logic [tcw_pkg::CHAR_W-1:0]    m_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]    m_read_attr
);

    import tcw_pkg::*;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   row_base_reg, row_base_next;
    logic [ADDR_W-1:0]   top_base_reg, top_base_next;
    logic [TAB_W-1:0]    phase_reg, phase_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                tab_reg, tab_next;
    logic                ret_put_reg, ret_put_next;
    logic [ADDR_W-1:0]   blank_addr_reg, blank_addr_next;
    logic [ADDR_W-1:0]   blank_last_reg, blank_last_next;
    logic [CELL_W-1:0]   blank_cell_reg, blank_cell_next;
    logic [COLOR_W-1:0]  fg_reg, bg_reg;
    logic                rd_ok_reg, rd_ok_next;
    logic [CHAR_W-1:0]   rd_char_reg, rd_char_next;
    logic [ATTR_W-1:0]   rd_attr_reg, rd_attr_next;
    logic                m_valid_reg, m_valid_next;
    logic [POS_W-1:0]    m_pos_reg;
    logic [CHAR_W-1:0]   m_char_reg;
    logic [ATTR_W-1:0]   m_attr_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic [ATTR_W-1:0]   attr;
    logic                col_full;
    logic                last_row;
    logic [TAB_W-1:0]    phase_inc;
    logic [ADDR_W:0]     top_sum;
    logic [ADDR_W-1:0]   top_adv;
    logic [ADDR_W-1:0]   lin_put;
    logic                line_feed;
    logic                finish;
    logic                out_free;
    logic                load;
    logic [ADDR_W:0]     pos_sum;

    // Screen memory
    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign attr      = {bg_reg, fg_reg};
    assign col_full  = col_reg >= COL_W'(COLUMNS);
    assign last_row  = row_reg == ROW_W'(ROWS - 1);
    assign phase_inc = (phase_reg == TAB_W'(TAB_WIDTH - 1)) ? '0 : phase_reg + TAB_W'(1);
    assign top_sum   = {1'b0, top_base_reg} + (ADDR_W + 1)'(COLUMNS);
    assign top_adv   = (top_sum >= (ADDR_W + 1)'(CELLS)) ? '0 : top_sum[ADDR_W-1:0];
    assign lin_put   = row_base_reg + ADDR_W'(col_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = state_reg == ST_IDLE;

    // Read address follows the request port; only used on a read transfer
    assign ram_raddr = cell_addr(ADDR_W'(s_cell_index), top_base_reg);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        row_base_next   = row_base_reg;
        top_base_next   = top_base_reg;
        phase_next      = phase_reg;
        ch_next         = ch_reg;
        tab_next        = tab_reg;
        ret_put_next    = ret_put_reg;
        blank_addr_next = blank_addr_reg;
        blank_last_next = blank_last_reg;
        blank_cell_next = blank_cell_reg;
        rd_ok_next      = rd_ok_reg;
        rd_char_next    = rd_char_reg;
        rd_attr_next    = rd_attr_reg;
        ram_we          = 1'b0;
        ram_waddr       = blank_addr_reg;
        ram_wdata       = blank_cell_reg;
        line_feed       = 1'b0;
        finish          = 1'b0;

        case (state_reg)
            ST_INIT: begin
                // Fill the screen with reset blanks
                ram_we    = 1'b1;
                ram_wdata = {RESET_ATTR, CH_BLANK};
                if (blank_addr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    blank_addr_next = blank_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    rd_ok_next   = 1'b0;
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    case (s_req_type)
                        REQ_PUT: begin
                            case (s_char_code)
                                CH_NL: begin
                                    line_feed    = 1'b1;
                                    ret_put_next = 1'b0;
                                    state_next   = ST_OUT;
                                end
                                CH_CR: begin
                                    col_next   = '0;
                                    phase_next = '0;
                                    state_next = ST_OUT;
                                end
                                CH_BS: begin
                                    if (col_reg != '0) begin
                                        col_next   = col_reg - COL_W'(1);
                                        phase_next = (phase_reg == '0) ?
                                                     TAB_W'(TAB_WIDTH - 1) :
                                                     phase_reg - TAB_W'(1);
                                    end
                                    state_next = ST_OUT;
                                end
                                CH_TAB: begin
                                    ch_next    = CH_BLANK;
                                    tab_next   = 1'b1;
                                    state_next = ST_PUT;
                                end
                                default: begin
                                    ch_next    = s_char_code;
                                    tab_next   = 1'b0;
                                    state_next = ST_PUT;
                                end
                            endcase
                        end
                        REQ_CLEAR: begin
                            blank_addr_next = '0;
                            blank_last_next = ADDR_W'(CELLS - 1);
                            blank_cell_next = {attr, CH_BLANK};
                            ret_put_next    = 1'b0;
                            top_base_next   = '0;
                            row_next        = '0;
                            row_base_next   = '0;
                            col_next        = '0;
                            phase_next      = '0;
                            state_next      = ST_BLANK;
                        end
                        REQ_READ: begin
                            rd_ok_next = s_cell_index < IDX_W'(CELLS);
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_PUT: begin
                if (col_full) begin
                    // Wrap before storing
                    line_feed    = 1'b1;
                    ret_put_next = 1'b1;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = cell_addr(lin_put, top_base_reg);
                    ram_wdata  = {attr, ch_reg};
                    col_next   = col_reg + COL_W'(1);
                    phase_next = phase_inc;
                    if (!(tab_reg && phase_inc != '0)) begin
                        finish = 1'b1;
                    end
                end
            end
            ST_BLANK: begin
                ram_we = 1'b1;
                if (blank_addr_reg == blank_last_reg) begin
                    state_next = ret_put_reg ? ST_PUT : ST_OUT;
                end else begin
                    blank_addr_next = blank_addr_reg + ADDR_W'(1);
                end
            end
            ST_READ: begin
                rd_char_next = rd_ok_reg ? ram_rdata[CHAR_W-1:0] : '0;
                rd_attr_next = rd_ok_reg ? ram_rdata[CELL_W-1:CHAR_W] : '0;
                finish       = 1'b1;
            end
            ST_OUT: begin
                finish = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the line, or rotate the screen and blank the new bottom row
        if (line_feed) begin
            col_next   = '0;
            phase_next = '0;
            if (!last_row) begin
                row_next      = row_reg + ROW_W'(1);
                row_base_next = row_base_reg + ADDR_W'(COLUMNS);
            end else begin
                top_base_next   = top_adv;
                blank_addr_next = top_base_reg;
                blank_last_next = top_base_reg + ADDR_W'(COLUMNS - 1);
                blank_cell_next = {attr, CH_BLANK};
                state_next      = ST_BLANK;
            end
        end

        // Hand the result to the output register, or wait for it to drain
        load = 1'b0;
        if (finish) begin
            if (out_free) begin
                load       = 1'b1;
                state_next = ST_IDLE;
            end else begin
                state_next = ST_OUT;
            end
        end
    end

    assign pos_sum = {1'b0, row_base_next} + (ADDR_W + 1)'(col_next);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            row_base_reg   <= '0;
            top_base_reg   <= '0;
            phase_reg      <= '0;
            blank_addr_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            row_base_reg   <= row_base_next;
            top_base_reg   <= top_base_next;
            phase_reg      <= phase_next;
            blank_addr_reg <= blank_addr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Color registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FG:  fg_reg <= cfg_wdata;
                CFG_BG:  bg_reg <= cfg_wdata;
                default: fg_reg <= fg_reg;
            endcase
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        ch_reg         <= ch_next;
        tab_reg        <= tab_next;
        ret_put_reg    <= ret_put_next;
        blank_last_reg <= blank_last_next;
        blank_cell_reg <= blank_cell_next;
        rd_ok_reg      <= rd_ok_next;
        rd_char_reg    <= rd_char_next;
        rd_attr_reg    <= rd_attr_next;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (load) begin
            m_pos_reg  <= POS_W'(pos_sum);
            m_char_reg <= rd_char_next;
            m_attr_reg <= rd_attr_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_pos_reg;
    assign m_read_char  = m_char_reg;
    assign m_read_attr  = m_attr_reg;

endmodule

@@ rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text-mode console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tcw_pkg::POS_W-1:0]     m_cursor_pos,
    input logic [tcw_pkg::CHAR_W-1:0]    m_read_char,
    input logic [tcw_pkg::ATTR_W-1:0]    m_read_attr
);

    import tcw_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_pos) &&
        $stable(m_read_char) && $stable(m_read_attr))
        else $error("result changed while stalled");

    // Refuse requests as the screen fill after reset begins
    a_init_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during reset fill");

    // One item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // Cursor never leaves the screen plus the one-past-end column
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cursor_pos <= POS_W'(CELLS))
        else $error("cursor position out of range");

endmodule

bind text_mode_console_writer_top tcw_checker u_tcw_checker (.*);

@@ tb/sv/text_mode_console_writer_top_tb.sv @@
// ----------------------------------------------------------------------------
// text_mode_console_writer_top_tb
// Self-checking bench for the 80x25 text console writer.
// ----------------------------------------------------------------------------
// A screen model in the bench tracks cells, cursor and colors. Each request
// it hands over is run through that model, and the cursor/cell report it
// yields is queued. Every report leaving the block is checked against the
// oldest queued one. A short directed table covers reset contents, field
// extremes, control bytes, line wrap and clear. Random text follows in
// lines of varied length so that the screen wraps and scrolls often. Three
// random phases change who idles. The receiver holds off for long
// stretches to back up the block, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top_tb;
    import tcw_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    // Init fill and clear run with no transfer; allow for those plus
    // receiver hold-offs several times over.
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_EVERY   = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int SHOWN_ERRORS = 10;

    // Request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] rd_char;
        logic [ATTR_W-1:0] rd_attr;
    } report_t;

    typedef struct {
        int                rep;
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        bit                typed;
        report_t           want;
    } plan_row_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_FG;
    logic [COLOR_W-1:0]   cfg_wdata    = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type   = REQ_PUT;
    logic [CHAR_W-1:0]    s_char_code  = '0;
    logic [IDX_W-1:0]     s_cell_index = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [POS_W-1:0]     m_cursor_pos;
    logic [CHAR_W-1:0]    m_read_char;
    logic [ATTR_W-1:0]    m_read_attr;

    // Screen model
    logic [CELL_W-1:0]  screen [CELLS];
    int                 cur_col;
    int                 cur_row;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;

    report_t   pending_reports [$];
    plan_row_t plan [$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatches    = 0;
    int        rx_count      = 0;
    int        hold_left     = 0;
    int        quiet_cycles  = 0;

    text_mode_console_writer_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_read_char  (m_read_char),
        .m_read_attr  (m_read_attr)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {bg_color, fg_color, CH_BLANK};
    endfunction

    // Go to column 0 of the next row, or scroll up and blank the bottom row
    function automatic void line_feed();
        cur_col = 0;
        if (cur_row + 1 < ROWS) begin
            cur_row++;
        end else begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int c = 0; c < COLUMNS; c++) screen[CELLS - COLUMNS + c] = blank_cell();
        end
    endfunction

    // Wrap at a full line, then store the byte and advance
    function automatic void store_glyph(input logic [CHAR_W-1:0] ch);
        int at;
        if (cur_col >= COLUMNS) line_feed();
        at = cur_row * COLUMNS + cur_col;
        if (at < CELLS) screen[at] = {bg_color, fg_color, ch};
        cur_col++;
    endfunction

    // Update the screen model for one request and return its report
    function automatic report_t apply_request(input logic [REQ_W-1:0] req,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [IDX_W-1:0] idx);
        report_t rep;
        rep = '0;
        case (req)
            REQ_PUT: begin
                case (ch)
                    CH_NL: line_feed();
                    CH_CR: cur_col = 0;
                    CH_TAB: begin
                        do store_glyph(CH_BLANK); while (cur_col % TAB_WIDTH != 0);
                    end
                    CH_BS: if (cur_col != 0) cur_col--;
                    default: store_glyph(ch);
                endcase
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
                cur_col = 0;
                cur_row = 0;
            end
            REQ_READ: begin
                if (idx < CELLS) begin
                    rep.rd_char = screen[idx][CHAR_W-1:0];
                    rep.rd_attr = screen[idx][CELL_W-1:CHAR_W];
                end
            end
            default: ;
        endcase
        rep.pos = POS_W'(cur_row * COLUMNS + cur_col);
        return rep;
    endfunction

    function automatic void plan_row(input int rep, input logic [REQ_W-1:0] req,
                                     input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx,
                                     input bit typed, input logic [POS_W-1:0] pos,
                                     input logic [CHAR_W-1:0] rc, input logic [ATTR_W-1:0] ra);
        plan_row_t row;
        row.rep   = rep;
        row.req   = req;
        row.ch    = ch;
        row.idx   = idx;
        row.typed = typed;
        row.want  = '{pos, rc, ra};
        plan.push_back(row);
    endfunction

    // Write both color registers back to back; only call while idle
    task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FG;
        cfg_wdata <= fg;
        @(posedge aclk);
        fg_color = fg;
        cfg_index <= CFG_BG;
        cfg_wdata <= bg;
        @(posedge aclk);
        bg_color = bg;
        cfg_we <= 1'b0;
    endtask

    // Offer one request, hold it until transfer, then queue its report
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx, input bit typed,
                                input report_t typed_want);
        report_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_char_code  <= ch;
        s_cell_index <= idx;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(req, ch, idx);
        pending_reports.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid and wait until every queued report has come back
    task automatic wait_idle(input int tail);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Random text in lines: mostly printable bytes and tabs, with reads,
    // backspaces, returns, stray requests and a rare clear mixed in
    task automatic send_random_text(input int n_items);
        int                left;
        int                line_len;
        int                pick;
        int                near;
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        left     = n_items;
        line_len = $urandom_range(0, 40);
        while (left > 0) begin
            req = REQ_PUT;
            ch  = CHAR_W'($urandom);
            idx = IDX_W'($urandom);
            if (line_len == 0) begin
                // end the line, then size the next one
                ch   = ($urandom_range(9) == 0) ? CH_CR : CH_NL;
                pick = $urandom_range(99);
                if (pick < 70) line_len = $urandom_range(0, 4);
                else if (pick < 90) line_len = $urandom_range(5, 40);
                else line_len = $urandom_range(60, 110);
            end else begin
                line_len--;
                pick = $urandom_range(999);
                if (pick < 3) begin
                    req = REQ_CLEAR;
                end else if (pick < 560) begin
                    req = REQ_PUT;
                end else if (pick < 660) begin
                    ch = CH_TAB;
                end else if (pick < 710) begin
                    ch = CH_BS;
                end else if (pick < 730) begin
                    ch = CH_CR;
                end else if (pick < 750) begin
                    req = REQ_UNUSED;
                end else begin
                    req  = REQ_READ;
                    pick = $urandom_range(9);
                    if (pick < 7) begin
                        // look back at recently written cells
                        near = cur_row * COLUMNS + cur_col - int'($urandom_range(0, 160));
                        if (near < 0) near = 0;
                        idx = IDX_W'(near);
                    end else if (pick == 9) begin
                        idx = IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1));
                    end
                end
            end
            send_request(req, ch, idx, 1'b0, '0);
            left--;
        end
    endtask

    // Receiver: random stalls plus a long hold-off every few hundred results
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_count++;
                if (rx_count % HOLD_EVERY == 0) hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check each result transfer against the oldest queued report
    always @(posedge aclk) begin
        report_t got;
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_cursor_pos, m_read_char, m_read_attr};
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: pos %0d char %h attr %h",
                             got.pos, got.rd_char, got.rd_attr);
            end else begin
                want = pending_reports.pop_front();
                if (got.pos !== want.pos || got.rd_char !== want.rd_char
                        || got.rd_attr !== want.rd_attr) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("mismatch: pos %0d/%0d char %h/%h attr %h/%h (exp/got)",
                                 want.pos, got.pos, want.rd_char, got.rd_char,
                                 want.rd_attr, got.rd_attr);
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CH_BLANK};
        cur_col  = 0;
        cur_row  = 0;
        fg_color = FG_RESET;
        bg_color = BG_RESET;

        // Directed table: rep, request, byte, cell, typed?, pos, char, attr
        plan_row(1, REQ_READ,   8'h00,  11'd0,    1, 11'd0,   CH_BLANK, RESET_ATTR);
        plan_row(1, REQ_READ,   8'hff,  11'd1999, 1, 11'd0,   CH_BLANK, RESET_ATTR);
        plan_row(1, REQ_READ,   8'h00,  11'd2047, 1, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_READ,   8'h00,  11'd2000, 1, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_UNUSED, 8'hff,  11'h7ff,  1, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    8'h00,  11'h7ff,  1, 11'd1,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    8'hff,  11'd0,    1, 11'd2,   8'h00,    8'h00);
        plan_row(1, REQ_READ,   8'h00,  11'd1,    1, 11'd2,   8'hff,    RESET_ATTR);
        plan_row(1, REQ_PUT,    CH_BS,  11'd0,    1, 11'd1,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    CH_BS,  11'd0,    1, 11'd0,   8'h00,    8'h00);
        // backspace at column zero stays put
        plan_row(1, REQ_PUT,    CH_BS,  11'd0,    1, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    CH_TAB, 11'd0,    1, 11'd8,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    CH_CR,  11'd0,    1, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    CH_NL,  11'd0,    1, 11'd80,  8'h00,    8'h00);
        // tabs run the column up to the full line, then a byte wraps
        plan_row(10, REQ_PUT,   CH_TAB, 11'd0,    0, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_PUT,    8'h57,  11'd0,    0, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_READ,   8'h00,  11'd160,  0, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_READ,   8'h00,  11'd159,  0, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_CLEAR,  8'h00,  11'd0,    1, 11'd0,   8'h00,    8'h00);
        plan_row(1, REQ_READ,   8'h00,  11'd160,  1, 11'd0,   CH_BLANK, RESET_ATTR);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_colors(FG_RESET, BG_RESET);

        send_idle_pct = 37;
        recv_idle_pct = 62;
        foreach (plan[i]) begin
            for (int r = 0; r < plan[i].rep; r++)
                send_request(plan[i].req, plan[i].ch, plan[i].idx, plan[i].typed, plan[i].want);
        end
        wait_idle(8);

        write_colors(4'h0, 4'hf);
        send_random_text(210);
        wait_idle(8);

        send_idle_pct = 62;
        recv_idle_pct = 37;
        write_colors(4'hf, 4'h0);
        send_random_text(100);
        // pause the sender until the block has emptied
        wait_idle(4);
        send_random_text(110);
        wait_idle(8);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
        send_random_text(210);
        wait_idle(16);

        mismatches += pending_reports.size();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_mode_console_writer_top.sv
rtl/tcw_checker.sv
tb/sv/text_mode_console_writer_top_tb.sv
